FILE: rtl/sipf_pkg.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer package
// Shared word types, protocol constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sipf_pkg;

  localparam logic [7:0]  HdrA       = 8'hFF;
  localparam logic [7:0]  HdrB       = 8'hFD;
  localparam logic [7:0]  HdrReserved = 8'h00;
  localparam logic [15:0] CrcPoly    = 16'h8005;
  localparam logic [7:0]  InstrWrite = 8'h03;
  localparam logic [7:0]  InstrRead  = 8'h02;
  localparam logic [7:0]  ReadLength = 8'd7;
  localparam logic [7:0]  LengthBias = 8'd5;

  localparam logic [4:0]  PosHdrA0    = 5'd0;
  localparam logic [4:0]  PosHdrA1    = 5'd1;
  localparam logic [4:0]  PosHdrB     = 5'd2;
  localparam logic [4:0]  PosReserved = 5'd3;
  localparam logic [4:0]  PosId       = 5'd4;
  localparam logic [4:0]  PosLenLo    = 5'd5;
  localparam logic [4:0]  PosLenHi    = 5'd6;
  localparam logic [4:0]  PosInstr    = 5'd7;
  localparam logic [4:0]  PosAddrLo   = 5'd8;
  localparam logic [4:0]  PosAddrHi   = 5'd9;
  localparam logic [4:0]  PosParam    = 5'd10;
  localparam logic [4:0]  PosLastBias = 5'd11;

  localparam logic [2:0]  ReadParamCount = 3'd2;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    KindWrite = 1'b0,
    KindRead  = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  servo_id;
    logic [15:0] reg_address;
    logic [31:0] data_value;
    logic [2:0]  byte_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  servo_id;
    logic [15:0] reg_address;
    logic [31:0] data_value;
    logic [2:0]  count;
    logic [7:0]  length;
    logic [4:0]  last_pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sipf_front.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer front end
// Accepts command words, clamps the count and works out the packet layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sipf_front
  import sipf_pkg::*;
#(
  parameter int MaxWriteBytes = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output cmd_t           push_cmd_o
);

  logic       slot_valid_q, slot_valid_d;
  cmd_t       slot_q, slot_d;
  logic       accept;
  logic [2:0] cnt;
  logic [2:0] params;

  assign in_stall_o = slot_valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = slot_valid_q && !q_status_i.full;
  assign push_cmd_o = slot_q;

  always_comb begin
    priority if (in_data_i.byte_count == 3'd0) begin
      cnt = 3'd1;
    end else if ({1'b0, in_data_i.byte_count} > 4'(MaxWriteBytes)) begin
      cnt = 3'(MaxWriteBytes);
    end else begin
      cnt = in_data_i.byte_count;
    end
    params = (in_data_i.kind == KindRead) ? ReadParamCount : cnt;

    slot_d.kind        = in_data_i.kind;
    slot_d.servo_id    = in_data_i.servo_id;
    slot_d.reg_address = in_data_i.reg_address;
    slot_d.data_value  = in_data_i.data_value;
    slot_d.count       = cnt;
    slot_d.length      = (in_data_i.kind == KindRead) ? ReadLength
                                                      : ({5'd0, cnt} + LengthBias);
    slot_d.last_pos    = PosLastBias + {2'd0, params};

    slot_valid_d = slot_valid_q;
    if (accept) begin
      slot_valid_d = 1'b1;
    end else if (push_o) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sipf_queue.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer command queue
// Short first-in first-out queue of classified commands between the halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sipf_queue
  import sipf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  push_cmd_i,
  input  wire logic  pop_i,
  output cmd_t       head_o,
  output q_status_t  status_o
);

  cmd_t             entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entries_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sipf_back.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer back end
// Serializes the head command into packet bytes and accumulates the CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sipf_back
  import sipf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_t      head_i,
  input  wire q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o
);

  logic [4:0]  pos_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  out_word_t   out_q;
  logic        load;
  logic        is_last;
  logic [4:0]  crc_pos;
  logic [4:0]  k;
  logic [7:0]  cur_byte;

  assign load        = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign crc_pos     = head_i.last_pos - 5'd1;
  assign is_last     = (pos_q == head_i.last_pos);
  assign pop_o       = load && is_last;
  assign k           = pos_q - PosParam;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    priority if (pos_q == head_i.last_pos) begin
      cur_byte = crc_q[15:8];
    end else if (pos_q == crc_pos) begin
      cur_byte = crc_q[7:0];
    end else if (pos_q >= PosParam) begin
      if (head_i.kind == KindRead) begin
        cur_byte = (k == 5'd0) ? {5'd0, head_i.count} : 8'h00;
      end else begin
        cur_byte = (k < 5'd4) ? head_i.data_value[{k[1:0], 3'b000} +: 8] : 8'h00;
      end
    end else begin
      unique case (pos_q)
        PosHdrA0, PosHdrA1: cur_byte = HdrA;
        PosHdrB:            cur_byte = HdrB;
        PosReserved:        cur_byte = HdrReserved;
        PosId:              cur_byte = head_i.servo_id;
        PosLenLo:           cur_byte = head_i.length;
        PosLenHi:           cur_byte = 8'h00;
        PosInstr:           cur_byte = (head_i.kind == KindRead) ? InstrRead : InstrWrite;
        PosAddrLo:          cur_byte = head_i.reg_address[7:0];
        default:            cur_byte = head_i.reg_address[15:8];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          pos_q <= '0;
          crc_q <= '0;
        end else begin
          pos_q <= pos_q + 5'd1;
          if (pos_q < crc_pos) begin
            crc_q <= crc_add(crc_q, cur_byte);
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.tx_byte   <= cur_byte;
      out_q.last_byte <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/servo_instruction_packet_framer.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer
// Turns read and write register commands into CRC-16 protected packets.
// ----------------------------------------------------------------------------
// Each accepted command word produces one packet, one byte per cycle while the
// output is not stalled: 12 plus the clamped byte count for a write, 14 for a
// read, so 13 to 16 bytes per command at the default width. The bytes come from
// the byte serializer in the back end, which folds each byte ahead of the CRC into it.
// A two-entry command queue lets new commands be taken while a packet is
// still going out, and consecutive packets follow back to back while it is not empty.
`timescale 1ns / 1ps
`default_nettype none

module servo_instruction_packet_framer
  import sipf_pkg::*;
#(
  parameter int MAX_WRITE_BYTES = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_data_o
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;

  sipf_front #(
    .MaxWriteBytes(MAX_WRITE_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .q_status_i(q_status),
    .push_o    (push),
    .push_cmd_o(push_cmd)
  );

  sipf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (q_status)
  );

  sipf_back u_back (
    .clk_i,
    .rst_ni,
    .head_i    (head),
    .q_status_i(q_status),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

`default_nettype wire

FILE: rtl/sipf_checker.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer checker
// Port-level checks on packet framing, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sipf_checker
  import sipf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_word_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_data_o
);

  logic [4:0] seen_q;
  logic       out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (out_acc) begin
      seen_q <= out_data_o.last_byte ? 5'd0 : seen_q + 5'd1;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q == 5'd0 |-> out_data_o.tx_byte == HdrA && !out_data_o.last_byte)
    else $error("packet does not open with the header byte");

  a_third_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q == 5'd2 |-> out_data_o.tx_byte == HdrB)
    else $error("third header byte is wrong");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_byte |-> seen_q >= 5'd12 && seen_q <= 5'd18)
    else $error("packet ends at an impossible length");

endmodule

bind servo_instruction_packet_framer sipf_checker u_sipf_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .in_data_i,
  .out_valid_o,
  .out_stall_i,
  .out_data_o
);

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Servo instruction packet framer testbench
// Sends read and write register commands and checks every packet byte that
// comes back against a packet builder held in the testbench, which also
// computes the CRC-16. A directed table with known packet sizes comes first,
// then random commands under several patterns of idle and stall cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sipf_pkg::*;

  localparam int MaxWriteBytes = 4;
  localparam int ClkHalf = 4;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 70;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 200000;
  localparam int NumRows = 18;

  typedef struct {
    in_word_t cmd;
    int       pkt_bytes;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  out_word_t expected_bytes[$];
  int        expected_sizes[$];
  int        fail_count = 0;
  int        seen_bytes = 0;
  int        popped_size;
  int        cycle_count = 0;
  int        send_pct = 0;
  int        stall_pct = 0;
  logic      hold_go = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;

  logic [15:0] framed_crc = '0;
  logic [4:0]  framed_len = '0;
  logic [58:0] framed_cmd = '0;

  stim_row_t dir_rows[NumRows];

  servo_instruction_packet_framer #(
    .MAX_WRITE_BYTES(MaxWriteBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  function automatic logic [15:0] crc16_8005(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return acc;
  endfunction

  function automatic int frame_packet(input in_word_t cmd);
    logic [7:0]  pkt[$];
    logic [15:0] len;
    logic [15:0] crc;
    int          n;
    n = cmd.byte_count;
    if (n < 1) n = 1;
    if (n > MaxWriteBytes) n = MaxWriteBytes;
    len = (cmd.kind == KindRead) ? 16'(ReadLength) : 16'(n + LengthBias);
    pkt = '{HdrA, HdrA, HdrB, HdrReserved, cmd.servo_id, len[7:0], len[15:8],
            (cmd.kind == KindRead) ? InstrRead : InstrWrite,
            cmd.reg_address[7:0], cmd.reg_address[15:8]};
    if (cmd.kind == KindRead) begin
      pkt.push_back(8'(n));
      pkt.push_back(8'h00);
    end else begin
      for (int k = 0; k < n; k++) begin
        pkt.push_back((k < 4) ? cmd.data_value[8*k +: 8] : 8'h00);
      end
    end
    crc = '0;
    foreach (pkt[i]) begin
      crc = crc16_8005(crc, pkt[i]);
      expected_bytes.push_back('{tx_byte: pkt[i], last_byte: 1'b0});
    end
    expected_bytes.push_back('{tx_byte: crc[7:0], last_byte: 1'b0});
    expected_bytes.push_back('{tx_byte: crc[15:8], last_byte: 1'b1});
    framed_crc = crc;
    framed_len = 5'(pkt.size() + 2);
    framed_cmd = {cmd.kind, 2'(n - 1), cmd.servo_id, cmd.reg_address, cmd.data_value};
    return pkt.size() + 2;
  endfunction

  task automatic send_cmd(input in_word_t cmd, input int pkt_bytes);
    int predicted;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    predicted = frame_packet(cmd);
    expected_sizes.push_back((pkt_bytes != 0) ? pkt_bytes : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: tx_byte %02h last_byte %0b",
               out_data_o.tx_byte, out_data_o.last_byte);
        fail_count = fail_count + 1;
      end else begin
        if (out_data_o.tx_byte !== expected_bytes[0].tx_byte) begin
          $error("tx_byte: expected %02h, got %02h",
                 expected_bytes[0].tx_byte, out_data_o.tx_byte);
          fail_count = fail_count + 1;
        end
        if (out_data_o.last_byte !== expected_bytes[0].last_byte) begin
          $error("last_byte: expected %0b, got %0b",
                 expected_bytes[0].last_byte, out_data_o.last_byte);
          fail_count = fail_count + 1;
        end
        void'(expected_bytes.pop_front());
      end
      seen_bytes = seen_bytes + 1;
      if (out_data_o.last_byte === 1'b1) begin
        if (expected_sizes.size() != 0) begin
          popped_size = expected_sizes.pop_front();
          if (popped_size != seen_bytes) begin
            $error("packet size: expected %0d, got %0d", popped_size, seen_bytes);
            fail_count = fail_count + 1;
          end
        end
        seen_bytes = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_word_t cmd;
    int       cnt;
    dir_rows = '{
      '{'{KindWrite, 8'h01, 16'h0074, 32'h0000_0001, 3'd1}, 13},
      '{'{KindWrite, 8'h01, 16'h0074, 32'h0000_ABCD, 3'd2}, 14},
      '{'{KindWrite, 8'h01, 16'h0074, 32'h00A1_B2C3, 3'd3}, 15},
      '{'{KindWrite, 8'h01, 16'h0074, 32'h1234_5678, 3'd4}, 16},
      '{'{KindRead,  8'h01, 16'h0084, 32'h0000_0000, 3'd1}, 14},
      '{'{KindRead,  8'h02, 16'h0084, 32'h0000_0000, 3'd2}, 14},
      '{'{KindRead,  8'h03, 16'h0084, 32'h0000_0000, 3'd4}, 14},
      '{'{KindWrite, 8'h00, 16'h0000, 32'h0000_0000, 3'd1}, 13},
      '{'{KindWrite, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd4}, 16},
      '{'{KindRead,  8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd4}, 14},
      '{'{KindWrite, 8'hFE, 16'h0040, 32'h0000_00FF, 3'd1}, 13},
      '{'{KindWrite, 8'h05, 16'h0010, 32'hCAFE_F00D, 3'd0}, 13},
      '{'{KindRead,  8'h05, 16'h0010, 32'h0000_0000, 3'd0}, 14},
      '{'{KindWrite, 8'h06, 16'h0020, 32'hDEAD_BEEF, 3'd7}, 16},
      '{'{KindWrite, 8'h06, 16'h0020, 32'h0BAD_CAFE, 3'd5}, 16},
      '{'{KindRead,  8'h07, 16'h0030, 32'h0000_0000, 3'd7}, 14},
      '{'{KindRead,  8'h00, 16'h0000, 32'hFFFF_FFFF, 3'd6}, 14},
      '{'{KindWrite, 8'h10, 16'h8000, 32'h8000_0001, 3'd3}, 15}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) send_cmd(dir_rows[r].cmd, dir_rows[r].pkt_bytes);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_pct = 0;
          stall_pct = 0;
          hold_go <= 1'b1;
        end
        1: begin
          send_pct = 66;
          stall_pct = 0;
        end
        2: begin
          send_pct = 0;
          stall_pct = 66;
        end
        default: begin
          send_pct = 10;
          stall_pct = 10;
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        cmd.kind        = 1'($urandom_range(1));
        cmd.servo_id    = ($urandom_range(9) == 0) ? 8'hFE : 8'($urandom);
        cmd.reg_address = 16'($urandom);
        cmd.data_value  = $urandom;
        cnt = ($urandom_range(99) < 85) ? $urandom_range(4, 1) : $urandom_range(7);
        cmd.byte_count  = 3'(cnt);
        send_cmd(cmd, 0);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
